>>> rtl/c65_pkg.sv
package c65_pkg;

  // Operation codes, alphabetical mnemonic order; codes above TYA run as NOP
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
    OP_LDY = 6'd28, OP_LSR = 6'd29, OP_NOP = 6'd30, OP_ORA = 6'd31,
    OP_PHA = 6'd32, OP_PHP = 6'd33, OP_PLA = 6'd34, OP_PLP = 6'd35,
    OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SBC = 6'd38, OP_SEC = 6'd39,
    OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43,
    OP_STY = 6'd44, OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47,
    OP_TXA = 6'd48, OP_TXS = 6'd49, OP_TYA = 6'd50
  } op_e;

  localparam logic [7:0] SP_RESET = 8'd253;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    flags_t     flags;
  } arch_t;

  typedef struct packed {
    logic [5:0] req_type;
    logic [7:0] operand;
    logic       accumulator_mode;
  } req_t;

  typedef struct packed {
    logic [7:0] write_data;
    logic       write_enable;
    logic [7:0] stack_addr;
    logic       stack_access;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] status_out;
  } rsp_t;

  // Status byte as seen on the bus: N V 1 B D I Z C with B and bit 5 set
  function automatic logic [7:0] pack_status(flags_t f);
    return {f.n, f.v, 1'b1, 1'b1, f.d, f.i, f.z, f.c};
  endfunction

endpackage

>>> rtl/c65_req_if.sv
interface c65_req_if;
  logic       valid;
  logic       ready;
  logic [5:0] req_type;
  logic [7:0] operand;
  logic       accumulator_mode;

  modport source (output valid, output req_type, output operand,
                  output accumulator_mode, input ready);
  modport sink   (input valid, input req_type, input operand,
                  input accumulator_mode, output ready);
endinterface

>>> rtl/c65_rsp_if.sv
interface c65_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] write_data;
  logic       write_enable;
  logic [7:0] stack_addr;
  logic       stack_access;
  logic       branch_taken;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] status_out;

  modport source (output valid, output write_data, output write_enable,
                  output stack_addr, output stack_access, output branch_taken,
                  output acc_out, output x_out, output y_out, output status_out,
                  input ready);
  modport sink   (input valid, input write_data, input write_enable,
                  input stack_addr, input stack_access, input branch_taken,
                  input acc_out, input x_out, input y_out, input status_out,
                  output ready);
endinterface

>>> rtl/cpu6502_execute_unit.sv
// Channel   Role    Beat payload
// --------  ------  ----------------------------------------------------------
// in_ch     sink    req_type[5:0], operand[7:0], accumulator_mode
// out_ch    source  write_data, write_enable, stack_addr, stack_access,
//                   branch_taken, acc_out, x_out, y_out, status_out
//
// One instruction per cycle sustained while out_ch keeps draining; an accepted beat sits in the input register,
// executes into the result register once that slot is free and is offered on out_ch from there.
// The register file updates at that same edge, so back-to-back instructions chain.
// Reset (rst_n low, synchronous) empties both registers; A=X=Y=0, SP=253, only I set.
// When out_ch stalls, the result register holds, the input register fills and
// in_ch.ready drops until the held result beat drains.
module cpu6502_execute_unit
  import c65_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  c65_req_if.sink   in_ch,
  c65_rsp_if.source out_ch
);

  logic  in_vld_r;
  req_t  req_r;
  logic  out_vld_r;
  rsp_t  rsp_r;

  logic  exec_go;
  arch_t arch_cur;
  arch_t arch_nxt;
  rsp_t  rsp_nxt;

  // Move the held instruction into the result register whenever that slot
  // is free or being drained this cycle
  assign exec_go     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || exec_go;

  // Input register: take a new beat whenever the held one leaves or none is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r.req_type         <= in_ch.req_type;
      req_r.operand          <= in_ch.operand;
      req_r.accumulator_mode <= in_ch.accumulator_mode;
    end
  end

  c65_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (exec_go),
    .nxt   (arch_nxt),
    .cur   (arch_cur)
  );

  c65_exec u_exec (
    .req (req_r),
    .cur (arch_cur),
    .nxt (arch_nxt),
    .rsp (rsp_nxt)
  );

  // Result register: hold while stalled, advance on each executed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.write_data   = rsp_r.write_data;
  assign out_ch.write_enable = rsp_r.write_enable;
  assign out_ch.stack_addr   = rsp_r.stack_addr;
  assign out_ch.stack_access = rsp_r.stack_access;
  assign out_ch.branch_taken = rsp_r.branch_taken;
  assign out_ch.acc_out      = rsp_r.acc_out;
  assign out_ch.x_out        = rsp_r.x_out;
  assign out_ch.y_out        = rsp_r.y_out;
  assign out_ch.status_out   = rsp_r.status_out;

endmodule

>>> rtl/c65_state.sv
module c65_state
  import c65_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  upd,
  input  arch_t nxt,
  output arch_t cur
);

  arch_t st_r;

  // Hold the programmer-visible registers; advance on each executed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.a     <= 8'd0;
      st_r.x     <= 8'd0;
      st_r.y     <= 8'd0;
      st_r.sp    <= SP_RESET;
      st_r.flags <= '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0};
    end else if (upd) begin
      st_r <= nxt;
    end
  end

  assign cur = st_r;

endmodule

>>> rtl/c65_exec.sv
module c65_exec
  import c65_pkg::*;
(
  input  req_t  req,
  input  arch_t cur,
  output arch_t nxt,
  output rsp_t  rsp
);

  logic [7:0] m;
  logic [7:0] src;
  logic [7:0] m_eff;
  logic [8:0] sum9;
  logic [7:0] cmp_reg;
  logic [8:0] diff9;
  logic       cin;
  logic       nz_en;
  logic [7:0] nz_val;
  logic       do_shift;
  logic [7:0] sh_res;
  logic       sh_c;
  logic [7:0] wdata;
  logic       wen;
  logic [7:0] saddr;
  logic       sacc;
  logic       br;

  assign m     = req.operand;
  assign cin   = cur.flags.c;
  assign src   = req.accumulator_mode ? cur.a : m;
  // SBC is ADC of the inverted operand
  assign m_eff = (op_e'(req.req_type) == OP_SBC) ? ~m : m;
  assign sum9  = {1'b0, cur.a} + {1'b0, m_eff} + {8'd0, cin};

  always_comb begin
    case (op_e'(req.req_type))
      OP_CPX:  cmp_reg = cur.x;
      OP_CPY:  cmp_reg = cur.y;
      default: cmp_reg = cur.a;
    endcase
  end

  assign diff9 = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    nxt      = cur;
    nz_en    = 1'b0;
    nz_val   = 8'd0;
    do_shift = 1'b0;
    sh_res   = 8'd0;
    sh_c     = 1'b0;
    wdata    = 8'd0;
    wen      = 1'b0;
    saddr    = 8'd0;
    sacc     = 1'b0;
    br       = 1'b0;

    unique case (op_e'(req.req_type))
      OP_ADC, OP_SBC: begin
        nxt.a       = sum9[7:0];
        nxt.flags.c = sum9[8];
        nxt.flags.v = ~(cur.a[7] ^ m_eff[7]) & (cur.a[7] ^ sum9[7]);
        nz_en       = 1'b1;
        nz_val      = sum9[7:0];
      end
      OP_AND: begin
        nxt.a = cur.a & m; nz_en = 1'b1; nz_val = cur.a & m;
      end
      OP_EOR: begin
        nxt.a = cur.a ^ m; nz_en = 1'b1; nz_val = cur.a ^ m;
      end
      OP_ORA: begin
        nxt.a = cur.a | m; nz_en = 1'b1; nz_val = cur.a | m;
      end
      OP_ASL: begin
        do_shift = 1'b1; sh_res = {src[6:0], 1'b0}; sh_c = src[7];
      end
      OP_LSR: begin
        do_shift = 1'b1; sh_res = {1'b0, src[7:1]}; sh_c = src[0];
      end
      OP_ROL: begin
        do_shift = 1'b1; sh_res = {src[6:0], cin}; sh_c = src[7];
      end
      OP_ROR: begin
        do_shift = 1'b1; sh_res = {cin, src[7:1]}; sh_c = src[0];
      end
      OP_BCC: br = ~cur.flags.c;
      OP_BCS: br = cur.flags.c;
      OP_BEQ: br = cur.flags.z;
      OP_BNE: br = ~cur.flags.z;
      OP_BMI: br = cur.flags.n;
      OP_BPL: br = ~cur.flags.n;
      OP_BVC: br = ~cur.flags.v;
      OP_BVS: br = cur.flags.v;
      OP_BIT: begin
        nxt.flags.z = ((cur.a & m) == 8'd0);
        nxt.flags.n = m[7];
        nxt.flags.v = m[6];
      end
      OP_CLC: nxt.flags.c = 1'b0;
      OP_CLD: nxt.flags.d = 1'b0;
      OP_CLI: nxt.flags.i = 1'b0;
      OP_CLV: nxt.flags.v = 1'b0;
      OP_SEC: nxt.flags.c = 1'b1;
      OP_SED: nxt.flags.d = 1'b1;
      OP_SEI: nxt.flags.i = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.flags.c = ~diff9[8];
        nxt.flags.z = (cmp_reg == m);
        nxt.flags.n = diff9[7];
      end
      OP_DEC: begin
        wdata = m - 8'd1; wen = 1'b1; nz_en = 1'b1; nz_val = m - 8'd1;
      end
      OP_INC: begin
        wdata = m + 8'd1; wen = 1'b1; nz_en = 1'b1; nz_val = m + 8'd1;
      end
      OP_DEX: begin
        nxt.x = cur.x - 8'd1; nz_en = 1'b1; nz_val = cur.x - 8'd1;
      end
      OP_DEY: begin
        nxt.y = cur.y - 8'd1; nz_en = 1'b1; nz_val = cur.y - 8'd1;
      end
      OP_INX: begin
        nxt.x = cur.x + 8'd1; nz_en = 1'b1; nz_val = cur.x + 8'd1;
      end
      OP_INY: begin
        nxt.y = cur.y + 8'd1; nz_en = 1'b1; nz_val = cur.y + 8'd1;
      end
      OP_LDA: begin
        nxt.a = m; nz_en = 1'b1; nz_val = m;
      end
      OP_LDX: begin
        nxt.x = m; nz_en = 1'b1; nz_val = m;
      end
      OP_LDY: begin
        nxt.y = m; nz_en = 1'b1; nz_val = m;
      end
      OP_PHA: begin
        saddr = cur.sp; sacc = 1'b1; wdata = cur.a; wen = 1'b1;
        nxt.sp = cur.sp - 8'd1;
      end
      OP_PHP: begin
        saddr = cur.sp; sacc = 1'b1; wdata = pack_status(cur.flags); wen = 1'b1;
        nxt.sp = cur.sp - 8'd1;
      end
      OP_PLA: begin
        // pre-increment, then take the operand as the pulled byte
        nxt.sp = cur.sp + 8'd1; saddr = cur.sp + 8'd1; sacc = 1'b1;
        nxt.a = m; nz_en = 1'b1; nz_val = m;
      end
      OP_PLP: begin
        nxt.sp = cur.sp + 8'd1; saddr = cur.sp + 8'd1; sacc = 1'b1;
        nxt.flags = '{n: m[7], v: m[6], d: m[3], i: m[2], z: m[1], c: m[0]};
      end
      OP_STA: begin
        wdata = cur.a; wen = 1'b1;
      end
      OP_STX: begin
        wdata = cur.x; wen = 1'b1;
      end
      OP_STY: begin
        wdata = cur.y; wen = 1'b1;
      end
      OP_TAX: begin
        nxt.x = cur.a; nz_en = 1'b1; nz_val = cur.a;
      end
      OP_TAY: begin
        nxt.y = cur.a; nz_en = 1'b1; nz_val = cur.a;
      end
      OP_TSX: begin
        nxt.x = cur.sp; nz_en = 1'b1; nz_val = cur.sp;
      end
      OP_TXA: begin
        nxt.a = cur.x; nz_en = 1'b1; nz_val = cur.x;
      end
      OP_TYA: begin
        nxt.a = cur.y; nz_en = 1'b1; nz_val = cur.y;
      end
      OP_TXS: nxt.sp = cur.x;
      default: begin
      end
    endcase

    if (do_shift) begin
      nxt.flags.c = sh_c;
      nz_en       = 1'b1;
      nz_val      = sh_res;
      if (req.accumulator_mode) begin
        nxt.a = sh_res;
      end else begin
        wdata = sh_res;
        wen   = 1'b1;
      end
    end

    if (nz_en) begin
      nxt.flags.n = nz_val[7];
      nxt.flags.z = (nz_val == 8'd0);
    end
  end

  always_comb begin
    rsp.write_data   = wdata;
    rsp.write_enable = wen;
    rsp.stack_addr   = saddr;
    rsp.stack_access = sacc;
    rsp.branch_taken = br;
    rsp.acc_out      = nxt.a;
    rsp.x_out        = nxt.x;
    rsp.y_out        = nxt.y;
    rsp.status_out   = pack_status(nxt.flags);
  end

endmodule

>>> sim/c65_exec_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the execute unit, runs its own copy of the
// architectural state and compares every result beat with the oldest
// prediction.
module c65_exec_checker
  import c65_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  c65_req_if        in_ch,
  c65_rsp_if        out_ch,
  output int        mismatches,
  output int        pending,
  output int        checked
);

  logic [7:0] reg_a;
  logic [7:0] reg_x;
  logic [7:0] reg_y;
  logic [7:0] reg_sp;
  flags_t     flg;

  rsp_t predicted_rsp_q[$];

  string field_name [9] = '{"write_data", "write_enable", "stack_addr", "stack_access",
                            "branch_taken", "acc_out", "x_out", "y_out", "status_out"};

  function automatic logic [7:0] status_byte();
    return {flg.n, flg.v, 2'b11, flg.d, flg.i, flg.z, flg.c};
  endfunction

  function automatic void set_nz(logic [7:0] v);
    flg.z = (v == 8'h00);
    flg.n = v[7];
  endfunction

  // Binary add into A; SBC comes in with the operand inverted
  function automatic void add_to_acc(logic [7:0] m);
    logic [8:0] sum;
    sum   = {1'b0, reg_a} + {1'b0, m} + {8'h00, flg.c};
    flg.c = sum[8];
    flg.v = ~(reg_a[7] ^ m[7]) & (reg_a[7] ^ sum[7]);
    reg_a = sum[7:0];
    set_nz(reg_a);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
    logic [7:0] diff;
    diff  = r - m;
    flg.c = (r >= m);
    flg.z = (r == m);
    flg.n = diff[7];
  endfunction

  function automatic rsp_t execute_instruction(req_t rq);
    rsp_t       r;
    logic [7:0] m;
    logic [7:0] src;
    logic [7:0] res;
    logic       cin;
    logic       shifted;
    r       = '0;
    m       = rq.operand;
    cin     = flg.c;
    shifted = 1'b0;
    src     = rq.accumulator_mode ? reg_a : m;
    res     = src;
    case (rq.req_type)
      OP_ADC: add_to_acc(m);
      OP_SBC: add_to_acc(~m);
      OP_AND: begin reg_a = reg_a & m; set_nz(reg_a); end
      OP_EOR: begin reg_a = reg_a ^ m; set_nz(reg_a); end
      OP_ORA: begin reg_a = reg_a | m; set_nz(reg_a); end
      OP_ASL: begin flg.c = src[7]; res = {src[6:0], 1'b0}; shifted = 1'b1; end
      OP_LSR: begin flg.c = src[0]; res = {1'b0, src[7:1]}; shifted = 1'b1; end
      OP_ROL: begin flg.c = src[7]; res = {src[6:0], cin}; shifted = 1'b1; end
      OP_ROR: begin flg.c = src[0]; res = {cin, src[7:1]}; shifted = 1'b1; end
      OP_BCC: r.branch_taken = ~flg.c;
      OP_BCS: r.branch_taken = flg.c;
      OP_BEQ: r.branch_taken = flg.z;
      OP_BNE: r.branch_taken = ~flg.z;
      OP_BMI: r.branch_taken = flg.n;
      OP_BPL: r.branch_taken = ~flg.n;
      OP_BVC: r.branch_taken = ~flg.v;
      OP_BVS: r.branch_taken = flg.v;
      OP_BIT: begin
        flg.z = ((reg_a & m) == 8'h00);
        flg.n = m[7];
        flg.v = m[6];
      end
      OP_CLC: flg.c = 1'b0;
      OP_CLD: flg.d = 1'b0;
      OP_CLI: flg.i = 1'b0;
      OP_CLV: flg.v = 1'b0;
      OP_SEC: flg.c = 1'b1;
      OP_SED: flg.d = 1'b1;
      OP_SEI: flg.i = 1'b1;
      OP_CMP: compare_reg(reg_a, m);
      OP_CPX: compare_reg(reg_x, m);
      OP_CPY: compare_reg(reg_y, m);
      OP_DEC, OP_INC: begin
        r.write_data   = (rq.req_type == OP_INC) ? m + 8'd1 : m - 8'd1;
        r.write_enable = 1'b1;
        set_nz(r.write_data);
      end
      OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
      OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
      OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
      OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
      OP_LDA: begin reg_a = m; set_nz(reg_a); end
      OP_LDX: begin reg_x = m; set_nz(reg_x); end
      OP_LDY: begin reg_y = m; set_nz(reg_y); end
      OP_PHA, OP_PHP: begin
        r.stack_addr   = reg_sp;
        r.stack_access = 1'b1;
        r.write_enable = 1'b1;
        r.write_data   = (rq.req_type == OP_PHA) ? reg_a : status_byte();
        reg_sp         = reg_sp - 8'd1;
      end
      OP_PLA, OP_PLP: begin
        reg_sp         = reg_sp + 8'd1;
        r.stack_addr   = reg_sp;
        r.stack_access = 1'b1;
        if (rq.req_type == OP_PLA) begin
          reg_a = m;
          set_nz(reg_a);
        end else begin
          flg = '{n: m[7], v: m[6], d: m[3], i: m[2], z: m[1], c: m[0]};
        end
      end
      OP_STA: begin r.write_data = reg_a; r.write_enable = 1'b1; end
      OP_STX: begin r.write_data = reg_x; r.write_enable = 1'b1; end
      OP_STY: begin r.write_data = reg_y; r.write_enable = 1'b1; end
      OP_TAX: begin reg_x = reg_a; set_nz(reg_x); end
      OP_TAY: begin reg_y = reg_a; set_nz(reg_y); end
      OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
      OP_TXA: begin reg_a = reg_x; set_nz(reg_a); end
      OP_TXS: reg_sp = reg_x;
      OP_TYA: begin reg_a = reg_y; set_nz(reg_a); end
      default: ;
    endcase
    if (shifted) begin
      set_nz(res);
      if (rq.accumulator_mode) begin
        reg_a = res;
      end else begin
        r.write_data   = res;
        r.write_enable = 1'b1;
      end
    end
    r.acc_out    = reg_a;
    r.x_out      = reg_x;
    r.y_out      = reg_y;
    r.status_out = status_byte();
    return r;
  endfunction

  function automatic logic [7:0] rsp_field(rsp_t r, int k);
    case (k)
      0:       return r.write_data;
      1:       return {7'd0, r.write_enable};
      2:       return r.stack_addr;
      3:       return {7'd0, r.stack_access};
      4:       return {7'd0, r.branch_taken};
      5:       return r.acc_out;
      6:       return r.x_out;
      7:       return r.y_out;
      default: return r.status_out;
    endcase
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    rsp_t got_r;
    logic bad;
    if (!rst_n) begin
      reg_a      = 8'h00;
      reg_x      = 8'h00;
      reg_y      = 8'h00;
      reg_sp     = SP_RESET;
      flg        = '0;
      flg.i      = 1'b1;
      mismatches = 0;
      checked    = 0;
      predicted_rsp_q.delete();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predicted_rsp_q.push_back(execute_instruction(
          '{req_type: in_ch.req_type, operand: in_ch.operand,
            accumulator_mode: in_ch.accumulator_mode}));
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got_r = '{write_data: out_ch.write_data, write_enable: out_ch.write_enable,
                  stack_addr: out_ch.stack_addr, stack_access: out_ch.stack_access,
                  branch_taken: out_ch.branch_taken, acc_out: out_ch.acc_out,
                  x_out: out_ch.x_out, y_out: out_ch.y_out, status_out: out_ch.status_out};
        if (predicted_rsp_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing outstanding, got %h", $time, got_r);
        end else begin
          exp_r = predicted_rsp_q.pop_front();
          bad   = 1'b0;
          for (int k = 0; k < 9; k++) begin
            if (rsp_field(exp_r, k) !== rsp_field(got_r, k)) begin
              bad = 1'b1;
              $display("%0t: beat %0d %s expected %02h, got %02h", $time, checked,
                       field_name[k], rsp_field(exp_r, k), rsp_field(got_r, k));
            end
          end
          if (bad) mismatches++;
          checked++;
        end
      end
    end
    pending = predicted_rsp_q.size();
  end

endmodule

>>> sim/tb_cpu6502_execute_unit.sv
`timescale 1ns / 100ps

module tb_cpu6502_execute_unit
  import c65_pkg::*;
;

  localparam int          RANDOM_ITEMS   = 1600;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam logic [5:0]  OP_UNUSED_LAST = 6'd63;

  logic clk;
  logic rst_n;

  c65_req_if req_ch ();
  c65_rsp_if rsp_ch ();

  int          mismatches;
  int          pending;
  int          checked;
  int          issued      = 0;
  int          long_stalls = 0;
  logic [63:0] ops_seen    = '0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;

  cpu6502_execute_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  c65_exec_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one instruction and hold it until the block takes the beat.
  // A gap drops valid first; with no gap valid stays high into the next beat.
  task automatic send_instr(input logic [5:0] code, input logic [7:0] opnd,
                            input logic accm);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= code;
    req_ch.operand          <= opnd;
    req_ch.accumulator_mode <= accm;
    // ready is sampled as it stood at the edge, before the block updates it
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    ops_seen[code] = 1'b1;
    issued++;
  endtask

  // Result side: random pauses, stretches of steady draining, and now and
  // then a long hold so the block backs up and drops in_ch.ready.
  initial begin
    int gap;
    int beats;
    beats = 0;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats % 40 == 0) take_steady = ($urandom_range(0, 3) == 0);
      if (beats == 150 || $urandom_range(0, 299) == 0) begin
        gap = $urandom_range(30, 60);
        long_stalls++;
      end else if (take_steady) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      beats++;
    end
  end

  // Watchdog: give up if the run hangs
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [5:0] code;
    logic [7:0] opnd;
    req_ch.valid            <= 1'b0;
    req_ch.req_type         <= OP_NOP;
    req_ch.operand          <= 8'h00;
    req_ch.accumulator_mode <= 1'b0;
    rst_n                   <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: push the reset status, then pull status bytes with every flag
    // set and every flag clear so each branch is seen taken.
    send_instr(OP_PHP, 8'h00, 1'b0);
    send_instr(OP_PLP, 8'hFF, 1'b0);   // bits 5 and 4 of the pulled byte drop
    send_instr(OP_BCS, 8'h00, 1'b0);
    send_instr(OP_BEQ, 8'h00, 1'b0);
    send_instr(OP_BMI, 8'h00, 1'b0);
    send_instr(OP_BVS, 8'h00, 1'b0);
    send_instr(OP_PLP, 8'h30, 1'b0);
    send_instr(OP_BCC, 8'h00, 1'b0);
    send_instr(OP_BNE, 8'h00, 1'b0);
    send_instr(OP_BPL, 8'h00, 1'b0);
    send_instr(OP_BVC, 8'h00, 1'b0);
    // Signed overflow on add, and subtract with borrow in and overflow
    send_instr(OP_LDA, 8'h7F, 1'b0);
    send_instr(OP_ADC, 8'h01, 1'b0);
    send_instr(OP_SBC, 8'h00, 1'b0);
    send_instr(OP_CMP, 8'h7F, 1'b0);
    // Shifts on A and on memory, carry feeding the rotates
    send_instr(OP_ASL, 8'h00, 1'b1);
    send_instr(OP_ROR, 8'h01, 1'b0);
    send_instr(OP_ROL, 8'h80, 1'b0);
    send_instr(OP_LSR, 8'hFF, 1'b1);
    // Increment ignores accumulator mode; both wrap
    send_instr(OP_INC, 8'hFF, 1'b1);
    send_instr(OP_DEC, 8'h00, 1'b0);
    // Stack pointer wrap on push and pull around zero
    send_instr(OP_LDX, 8'h00, 1'b0);
    send_instr(OP_TXS, 8'h00, 1'b0);
    send_instr(OP_PHA, 8'h00, 1'b0);
    send_instr(OP_PLA, 8'h80, 1'b0);
    send_instr(OP_SED, 8'h00, 1'b0);
    send_instr(OP_ADC, 8'hFF, 1'b0);   // decimal flag set, add stays binary
    send_instr(OP_UNUSED_LAST, 8'hFF, 1'b1);
    send_instr(OP_TSX, 8'h00, 1'b0);

    // Random: mostly defined operations, operands leaning on the corners
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) send_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) code = 6'($urandom_range(OP_TYA + 1, OP_UNUSED_LAST));
      else                           code = 6'($urandom_range(OP_ADC, OP_TYA));
      case ($urandom_range(0, 7))
        0:       opnd = 8'h00;
        1:       opnd = 8'hFF;
        2:       opnd = ($urandom_range(0, 1) == 0) ? 8'h7F : 8'h80;
        default: opnd = 8'($urandom_range(0, 255));
      endcase
      send_instr(code, opnd, 1'($urandom_range(0, 1)));
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every predicted beat, then watch for stray beats
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions sent over %0d of 64 operation codes, %0d results compared",
             issued, $countones(ops_seen), checked);
    $display("%0d long result-side holds forced input backpressure", long_stalls);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      if (pending != 0) $display("%0t: %0d predicted results never arrived", $time, pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
